[design/rlel_pkg.sv]
// Shared types and constants for the run-length coded RGB565 layer decoder.
// Used by rlel_core and by the top level rle_rgb565_layer_decode; no dependencies.
package rlel_pkg;

  // One byte of the coded layer stream.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       layer_start;
  } in_item_t;

  // One decoded result: a pixel write, an end-of-layer marker, or both.
  typedef struct packed {
    logic        pixel_valid;
    logic [23:0] pixel_address;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
    logic        layer_done;
  } out_item_t;

  // Configuration register indexes.
  typedef enum logic [0:0] {
    REG_LAYER_BASE = 1'b0,
    REG_LINE_PITCH = 1'b1
  } cfg_reg_t;

  // Decoder phases.
  typedef enum logic [2:0] {
    PH_DONE    = 3'd0,
    PH_HEADER  = 3'd1,
    PH_CONTROL = 3'd2,
    PH_PIX_LO  = 3'd3,
    PH_PIX_HI  = 3'd4
  } phase_t;

  localparam int unsigned BASE_WIDTH  = 24;
  localparam int unsigned PITCH_WIDTH = 13;
  localparam int unsigned CFG_WIDTH   = 24;

  // Control byte codes and header layout.
  localparam logic [7:0] CTRL_NEW_LINE_A = 8'h00;
  localparam logic [7:0] CTRL_NEW_LINE_B = 8'h80;
  localparam logic [3:0] HEADER_SIZE_BYTES = 4'd4;
  localparam logic [3:0] HEADER_LAST       = 4'd15;

endpackage

[design/rlel_core.sv]
// Decoder state and combinational next-state logic for the RLE RGB565 layer decoder.
// Depends on rlel_pkg; instantiated by rle_rgb565_layer_decode.
module rlel_core #(
  parameter int ADDR_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   step,
  input  rlel_pkg::in_item_t                     item,
  input  logic [rlel_pkg::BASE_WIDTH-1:0]        layer_base_address,
  input  logic [rlel_pkg::PITCH_WIDTH-1:0]       line_pitch,
  output logic                                   res_valid,
  output rlel_pkg::out_item_t                    res
);

  rlel_pkg::phase_t       phase, phase_eff, phase_next;
  logic [3:0]             header_index, hidx_eff, hidx_next;
  logic [31:0]            remaining_size, size_eff, size_next;
  logic [6:0]             run_left, run_eff, run_next;
  logic [7:0]             low_half, low_eff, low_next;
  logic [ADDR_BITS-1:0]   row_base, row_eff, row_next;
  logic [ADDR_BITS-1:0]   write_pointer, wp_eff, wp_next;
  logic [ADDR_BITS-1:0]   base_wrapped;
  logic [31:0]            base_ext;
  logic [31:0]            addr_ext;
  logic [15:0]            pixel_word;
  logic [7:0]             dbyte;

  function automatic logic size_positive(input logic [31:0] size);
    return (size != 32'd0) && !size[31];
  endfunction

  assign dbyte        = item.data_byte;
  assign base_ext     = 32'(layer_base_address);
  assign base_wrapped = base_ext[ADDR_BITS-1:0];

  // A layer start overrides whatever state is held and makes this byte header byte 0.
  always_comb begin
    phase_eff = phase;
    hidx_eff  = header_index;
    size_eff  = remaining_size;
    run_eff   = run_left;
    low_eff   = low_half;
    row_eff   = row_base;
    wp_eff    = write_pointer;
    if (item.layer_start) begin
      phase_eff = rlel_pkg::PH_HEADER;
      hidx_eff  = 4'd0;
      size_eff  = 32'd0;
      run_eff   = 7'd0;
      low_eff   = 8'd0;
      row_eff   = base_wrapped;
      wp_eff    = base_wrapped;
    end
  end

  // Next state.
  always_comb begin
    phase_next = phase_eff;
    hidx_next  = hidx_eff;
    size_next  = size_eff;
    run_next   = run_eff;
    low_next   = low_eff;
    row_next   = row_eff;
    wp_next    = wp_eff;
    unique case (phase_eff)
      rlel_pkg::PH_HEADER: begin
        if (hidx_eff < rlel_pkg::HEADER_SIZE_BYTES) begin
          size_next = size_eff | (32'(dbyte) << {hidx_eff[1:0], 3'b000});
        end
        if (hidx_eff == rlel_pkg::HEADER_LAST) begin
          hidx_next  = 4'd0;
          phase_next = size_positive(size_eff) ? rlel_pkg::PH_CONTROL : rlel_pkg::PH_DONE;
        end else begin
          hidx_next = hidx_eff + 4'd1;
        end
      end
      rlel_pkg::PH_CONTROL: begin
        priority if (dbyte == rlel_pkg::CTRL_NEW_LINE_A ||
                     dbyte == rlel_pkg::CTRL_NEW_LINE_B) begin
          row_next  = row_eff + ADDR_BITS'(line_pitch);
          wp_next   = row_next;
          size_next = size_eff - 32'd1;
          if (!size_positive(size_next)) begin
            phase_next = rlel_pkg::PH_DONE;
          end
        end else if (dbyte[7]) begin
          // Run byte: the whole run is charged against the size up front.
          run_next   = dbyte[6:0];
          size_next  = size_eff - 32'({dbyte[6:0], 1'b1});
          phase_next = rlel_pkg::PH_PIX_LO;
        end else begin
          wp_next   = wp_eff + ADDR_BITS'(dbyte);
          size_next = size_eff - 32'd1;
          if (!size_positive(size_next)) begin
            phase_next = rlel_pkg::PH_DONE;
          end
        end
      end
      rlel_pkg::PH_PIX_LO: begin
        low_next   = dbyte;
        phase_next = rlel_pkg::PH_PIX_HI;
      end
      rlel_pkg::PH_PIX_HI: begin
        wp_next  = wp_eff + ADDR_BITS'(1);
        run_next = run_eff - 7'd1;
        priority if (run_next != 7'd0) begin
          phase_next = rlel_pkg::PH_PIX_LO;
        end else if (size_positive(size_eff)) begin
          phase_next = rlel_pkg::PH_CONTROL;
        end else begin
          phase_next = rlel_pkg::PH_DONE;
        end
      end
      rlel_pkg::PH_DONE: begin
        phase_next = rlel_pkg::PH_DONE;
      end
      default: begin
        phase_next = rlel_pkg::PH_DONE;
      end
    endcase
  end

  // Result for this byte.
  assign pixel_word = {dbyte, low_eff};
  assign addr_ext   = 32'(wp_eff);

  always_comb begin
    res_valid = 1'b0;
    res       = '0;
    unique case (phase_eff)
      rlel_pkg::PH_HEADER: begin
        if (hidx_eff == rlel_pkg::HEADER_LAST && !size_positive(size_eff)) begin
          res_valid      = step;
          res.layer_done = 1'b1;
        end
      end
      rlel_pkg::PH_CONTROL: begin
        if (!dbyte[7] || dbyte == rlel_pkg::CTRL_NEW_LINE_B) begin
          if (!size_positive(size_next)) begin
            res_valid      = step;
            res.layer_done = 1'b1;
          end
        end
      end
      rlel_pkg::PH_PIX_HI: begin
        res_valid         = step;
        res.pixel_valid   = 1'b1;
        res.pixel_address = addr_ext[23:0];
        res.blue          = {pixel_word[4:0], 3'b000};
        res.green         = {pixel_word[10:5], 2'b00};
        res.red           = {pixel_word[15:11], 3'b000};
        res.layer_done    = (run_eff == 7'd1) && !size_positive(size_eff);
      end
      default: begin
        res_valid = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= rlel_pkg::PH_DONE;
      header_index   <= 4'd0;
      remaining_size <= 32'd0;
      run_left       <= 7'd0;
      low_half       <= 8'd0;
      row_base       <= '0;
      write_pointer  <= '0;
    end else if (step) begin
      phase          <= phase_next;
      header_index   <= hidx_next;
      remaining_size <= size_next;
      run_left       <= run_next;
      low_half       <= low_next;
      row_base       <= row_next;
      write_pointer  <= wp_next;
    end
  end

`ifndef ASSERT_OFF
  // An end-only marker never carries pixel data.
  a_end_marker_clean: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res.pixel_valid |-> res.layer_done && res.pixel_address == 24'd0)
    else $error("end marker carries pixel data");

  // Once the layer is finished, bytes without a layer start produce nothing.
  a_done_is_silent: assert property (@(posedge clk) disable iff (rst)
    step && phase == rlel_pkg::PH_DONE && !item.layer_start |-> !res_valid)
    else $error("result produced after layer end");

  // While inside a run, at least one pixel is still owed.
  a_run_nonzero: assert property (@(posedge clk) disable iff (rst)
    phase == rlel_pkg::PH_PIX_LO || phase == rlel_pkg::PH_PIX_HI |-> run_left != 7'd0)
    else $error("pixel phase with empty run");

  // The header counter only moves while the header is being read.
  a_header_idx_scope: assert property (@(posedge clk) disable iff (rst)
    header_index != 4'd0 |-> phase == rlel_pkg::PH_HEADER)
    else $error("header index nonzero outside header");
`endif

endmodule

[design/rle_rgb565_layer_decode.sv]
// Top level of the run-length coded RGB565 layer decoder: ports, configuration
// registers and the output register. Depends on rlel_pkg and rlel_core.
//
// The block takes a coded image layer one byte per item and emits pixel writes.
// A layer begins with a byte marked layer_start, which is header byte 0 of a
// 16-byte header whose first four bytes are a little-endian signed size. Control
// bytes follow: 0x00 or 0x80 opens a new scanline at the previous line start
// plus line_pitch, 0x01..0x7f skips that many pixels, and 0x81..0xff introduces
// (byte & 0x7f) two-byte RGB565 pixels, low byte first. Each pixel comes out as
// one item with its frame address and blue, green and red widened to eight
// bits. The layer ends when the running size reaches zero or below; the last
// pixel then carries layer_done, or, if a control byte or the header ends the
// layer, an item with only layer_done set is sent. Bytes after the end are
// dropped until the next layer_start, and a layer_start at any time restarts.
// The base address is taken when a layer starts; the user must write the
// configuration only while the block is idle, which the block does not enforce.
// Internal addresses are ADDR_BITS wide and wrap at that width; pixel_address
// shows the low 24 bits. Rate: one byte per clock cycle while the output is not
// stalled. Every byte updates the decoder state and the result lands in one output
// register; while that register holds an item that is not yet taken, in_ready follows
// out_ready, so a byte is accepted in the same cycle that the held item leaves.
module rle_rgb565_layer_decode #(
  parameter int ADDR_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  rlel_pkg::in_item_t                  in_data,
  output logic                                out_valid,
  input  logic                                out_ready,
  output rlel_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  rlel_pkg::cfg_reg_t                  cfg_index,
  input  logic [rlel_pkg::CFG_WIDTH-1:0]      cfg_data
);

  logic [rlel_pkg::BASE_WIDTH-1:0]  layer_base_address;
  logic [rlel_pkg::PITCH_WIDTH-1:0] line_pitch;
  logic                             in_accept;
  logic                             res_valid;
  rlel_pkg::out_item_t              res;

  // Configuration registers: plain writes, no read-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      layer_base_address <= '0;
      line_pitch         <= rlel_pkg::PITCH_WIDTH'(1);
    end else if (cfg_we) begin
      unique case (cfg_index)
        rlel_pkg::REG_LAYER_BASE: layer_base_address <= cfg_data[rlel_pkg::BASE_WIDTH-1:0];
        rlel_pkg::REG_LINE_PITCH: line_pitch         <= cfg_data[rlel_pkg::PITCH_WIDTH-1:0];
      endcase
    end
  end

  // A new byte can enter whenever the output register is empty or being emptied.
  assign in_ready  = !out_valid || out_ready;
  assign in_accept = in_valid && in_ready;

  rlel_core #(
    .ADDR_BITS (ADDR_BITS)
  ) u_core (
    .clk                (clk),
    .rst                (rst),
    .step               (in_accept),
    .item               (in_data),
    .layer_base_address (layer_base_address),
    .line_pitch         (line_pitch),
    .res_valid          (res_valid),
    .res                (res)
  );

  // Output register. Bytes that produce no result simply let a taken item go.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_data <= res;
    end
  end

endmodule

[verif/rle_rgb565_layer_decode_checker.sv]
`timescale 1ns / 1ps
// Checker for rle_rgb565_layer_decode: follows the configuration port and both
// item channels, predicts every pixel write and end marker, and compares them.
// Depends on rlel_pkg only.
module rle_rgb565_layer_decode_checker #(
  parameter int ADDR_BITS = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_ready,
  input  rlel_pkg::in_item_t                  in_data,
  input  logic                                out_valid,
  input  logic                                out_ready,
  input  rlel_pkg::out_item_t                 out_data,
  input  logic                                cfg_we,
  input  rlel_pkg::cfg_reg_t                  cfg_index,
  input  logic [rlel_pkg::CFG_WIDTH-1:0]      cfg_data,
  output int                                  errors,
  output int                                  pending,
  output int                                  pixels_seen,
  output int                                  ends_seen
);

  localparam int MAX_PRINTED = 40;

  // Shadow configuration and decoder state.
  logic [rlel_pkg::BASE_WIDTH-1:0]  base_reg;
  logic [rlel_pkg::PITCH_WIDTH-1:0] pitch_reg;
  rlel_pkg::phase_t                 phase;
  logic [3:0]                       hdr_idx;
  logic [31:0]                      size_left;
  logic [6:0]                       run_left;
  logic [7:0]                       low_half;
  logic [31:0]                      line_start;
  logic [31:0]                      wr_ptr;

  // Pixel writes and end markers that the block still owes.
  rlel_pkg::out_item_t writes_due[$];

  function automatic logic [31:0] wrap_addr(input logic [63:0] a);
    return 32'(a & ((64'd1 << ADDR_BITS) - 64'd1));
  endfunction

  function automatic logic size_above_zero();
    return (size_left != 32'd0) && !size_left[31];
  endfunction

  // Advances the shadow decoder by one stream byte; returns 1 when it yields a result.
  function automatic bit decode_byte(input rlel_pkg::in_item_t it,
                                     output rlel_pkg::out_item_t res);
    logic [7:0]  b;
    logic [15:0] word;
    b = it.data_byte;
    res = '0;
    if (it.layer_start) begin
      phase = rlel_pkg::PH_HEADER;
      hdr_idx = '0;
      size_left = '0;
      run_left = '0;
      low_half = '0;
      line_start = wrap_addr(64'(base_reg));
      wr_ptr = line_start;
    end
    case (phase)
      rlel_pkg::PH_HEADER: begin
        if (hdr_idx < rlel_pkg::HEADER_SIZE_BYTES) begin
          size_left = size_left | (32'(b) << (8 * hdr_idx));
        end
        if (hdr_idx >= rlel_pkg::HEADER_LAST) begin
          hdr_idx = '0;
          if (size_above_zero()) begin
            phase = rlel_pkg::PH_CONTROL;
            return 1'b0;
          end
          phase = rlel_pkg::PH_DONE;
          res.layer_done = 1'b1;
          return 1'b1;
        end
        hdr_idx = hdr_idx + 4'd1;
        return 1'b0;
      end
      rlel_pkg::PH_CONTROL: begin
        if (b == rlel_pkg::CTRL_NEW_LINE_A || b == rlel_pkg::CTRL_NEW_LINE_B) begin
          line_start = wrap_addr(64'(line_start) + 64'(pitch_reg));
          wr_ptr = line_start;
          size_left = size_left - 32'd1;
        end else if (b > rlel_pkg::CTRL_NEW_LINE_B) begin
          // The whole run is charged up front; its pixels are still read.
          run_left = b[6:0];
          size_left = size_left - (32'(run_left) * 32'd2 + 32'd1);
          phase = rlel_pkg::PH_PIX_LO;
          return 1'b0;
        end else begin
          wr_ptr = wrap_addr(64'(wr_ptr) + 64'(b));
          size_left = size_left - 32'd1;
        end
        if (size_above_zero()) begin
          return 1'b0;
        end
        phase = rlel_pkg::PH_DONE;
        res.layer_done = 1'b1;
        return 1'b1;
      end
      rlel_pkg::PH_PIX_LO: begin
        low_half = b;
        phase = rlel_pkg::PH_PIX_HI;
        return 1'b0;
      end
      rlel_pkg::PH_PIX_HI: begin
        word = {b, low_half};
        res.pixel_valid = 1'b1;
        res.pixel_address = wr_ptr[23:0];
        res.blue = {word[4:0], 3'b000};
        res.green = {word[10:5], 2'b00};
        res.red = {word[15:11], 3'b000};
        wr_ptr = wrap_addr(64'(wr_ptr) + 64'd1);
        run_left = run_left - 7'd1;
        if (run_left != 7'd0) begin
          phase = rlel_pkg::PH_PIX_LO;
        end else if (size_above_zero()) begin
          phase = rlel_pkg::PH_CONTROL;
        end else begin
          phase = rlel_pkg::PH_DONE;
          res.layer_done = 1'b1;
        end
        return 1'b1;
      end
      default: begin
        phase = rlel_pkg::PH_DONE;
        return 1'b0;
      end
    endcase
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] want_v,
                                 input logic [31:0] got_v);
    errors++;
    if (errors <= MAX_PRINTED) begin
      $display("%0t: mismatch in %s, expected 0x%0h, got 0x%0h", $time, what, want_v, got_v);
    end
  endtask

  always @(posedge clk) begin
    rlel_pkg::out_item_t want;
    rlel_pkg::out_item_t got;
    if (rst) begin
      base_reg = '0;
      pitch_reg = rlel_pkg::PITCH_WIDTH'(1);
      phase = rlel_pkg::PH_DONE;
      hdr_idx = '0;
      size_left = '0;
      run_left = '0;
      low_half = '0;
      line_start = '0;
      wr_ptr = '0;
      writes_due.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          rlel_pkg::REG_LAYER_BASE: base_reg = cfg_data[rlel_pkg::BASE_WIDTH-1:0];
          rlel_pkg::REG_LINE_PITCH: pitch_reg = cfg_data[rlel_pkg::PITCH_WIDTH-1:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (decode_byte(in_data, want)) begin
          writes_due.push_back(want);
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        if (writes_due.size() == 0) begin
          report_mismatch("result with nothing expected, address", 32'd0,
                          32'(got.pixel_address));
        end else begin
          want = writes_due.pop_front();
          if (got.pixel_valid !== want.pixel_valid) begin
            report_mismatch("pixel_valid", 32'(want.pixel_valid), 32'(got.pixel_valid));
          end
          if (got.pixel_address !== want.pixel_address) begin
            report_mismatch("pixel_address", 32'(want.pixel_address),
                            32'(got.pixel_address));
          end
          if (got.blue !== want.blue) begin
            report_mismatch("blue", 32'(want.blue), 32'(got.blue));
          end
          if (got.green !== want.green) begin
            report_mismatch("green", 32'(want.green), 32'(got.green));
          end
          if (got.red !== want.red) begin
            report_mismatch("red", 32'(want.red), 32'(got.red));
          end
          if (got.layer_done !== want.layer_done) begin
            report_mismatch("layer_done", 32'(want.layer_done), 32'(got.layer_done));
          end
          if (want.pixel_valid) begin
            pixels_seen++;
          end
          if (want.layer_done) begin
            ends_seen++;
          end
        end
      end
    end
    pending <= writes_due.size();
  end

endmodule

[verif/rle_rgb565_layer_decode_tb.sv]
`timescale 1ns / 1ps
// Testbench top for rle_rgb565_layer_decode: builds coded layer streams, writes
// the configuration, applies back-pressure and prints the verdict.
// Depends on rlel_pkg, the block and rle_rgb565_layer_decode_checker.
module rle_rgb565_layer_decode_tb;

  // Cycles without any accepted item before the run is declared hung. The
  // longest legal quiet stretch is a long sender gap followed by a long
  // receiver stall, so this is ample.
  localparam int WATCHDOG_LIMIT = 2000;
  // Stream bytes to send in the random part before stopping.
  localparam int RANDOM_BYTES   = 450;
  // The block has a single output register; this drain covers anything in flight.
  localparam int DRAIN_CYCLES   = 8;

  logic                           clk;
  logic                           rst;
  logic                           in_valid;
  logic                           in_ready;
  rlel_pkg::in_item_t             in_data;
  logic                           out_valid;
  logic                           out_ready;
  rlel_pkg::out_item_t            out_data;
  logic                           cfg_we;
  rlel_pkg::cfg_reg_t             cfg_index;
  logic [rlel_pkg::CFG_WIDTH-1:0] cfg_data;

  // Figures handed up by the checker.
  int errors;
  int pending;
  int pixels_seen;
  int ends_seen;

  // When quiet is set, neither the sender nor the receiver inserts gaps.
  bit quiet;
  int stall_left;
  int idle_cycles;
  int bytes_sent;
  int random_bytes;
  int layer_count;
  int setting_count;

  // Bytes of the layers being assembled, sent in order by send_stream.
  rlel_pkg::in_item_t stream_q[$];

  rle_rgb565_layer_decode #(
    .ADDR_BITS(24)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  rle_rgb565_layer_decode_checker #(
    .ADDR_BITS(24)
  ) pixel_check (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .errors     (errors),
    .pending    (pending),
    .pixels_seen(pixels_seen),
    .ends_seen  (ends_seen)
  );

  initial clk = 1'b0;
  always #10 clk = ~clk;

  // Gap lengths: mostly none or short, now and then a long one.
  function automatic int pick_gap();
    int r;
    if (quiet) begin
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 55) begin
      return 0;
    end
    if (r < 85) begin
      return $urandom_range(1, 3);
    end
    if (r < 97) begin
      return $urandom_range(4, 12);
    end
    return $urandom_range(20, 60);
  endfunction

  // Receiver: ready most of the time, with stalls of random length that
  // start at random points, so they land on every phase of the decoder.
  always @(posedge clk) begin
    if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 35) begin
        stall_left = pick_gap();
      end
    end
  end

  // Watchdog: any accepted item on either channel restarts the count.
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Watchdog expired after %0d cycles with no item accepted", idle_cycles);
      $display("FAILURE");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic s);
    stream_q.push_back('{data_byte: b, layer_start: s});
  endtask

  // Presents one item after an optional gap and holds it until accepted.
  // With no gap, valid simply stays high from the previous item.
  task automatic send_item(input rlel_pkg::in_item_t it);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic send_stream();
    foreach (stream_q[k]) begin
      send_item(stream_q[k]);
    end
    stream_q.delete();
  endtask

  // Drops valid and waits until the block owes nothing, then waits out
  // DRAIN_CYCLES for a byte that produced no result to settle. The first edge
  // lets the checker account for the last accepted byte.
  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes both registers on consecutive cycles; the write enable is held
  // across the pair and lowered once.
  task automatic configure(input logic [rlel_pkg::BASE_WIDTH-1:0] base,
                           input logic [rlel_pkg::PITCH_WIDTH-1:0] pitch);
    cfg_we <= 1'b1;
    cfg_index <= rlel_pkg::REG_LAYER_BASE;
    cfg_data <= rlel_pkg::CFG_WIDTH'(base);
    @(posedge clk);
    cfg_index <= rlel_pkg::REG_LINE_PITCH;
    cfg_data <= rlel_pkg::CFG_WIDTH'(pitch);
    @(posedge clk);
    cfg_we <= 1'b0;
    setting_count++;
  endtask

  // Builds one layer: a random control stream, then a header whose size
  // either matches the stream exactly (the usual case), ends it early,
  // overshoots it so the next layer start cuts it off, is zero or negative,
  // or the whole layer is truncated at a random byte.
  task automatic add_layer();
    rlel_pkg::in_item_t body[$];
    rlel_pkg::in_item_t whole[$];
    logic [31:0]        size;
    int                 n_ops;
    int                 pick;
    int                 cnt;
    int                 mode;
    int                 keep;
    n_ops = $urandom_range(2, 10);
    for (int k = 0; k < n_ops; k++) begin
      pick = $urandom_range(0, 99);
      if (pick < 15) begin
        body.push_back('{data_byte: ($urandom_range(0, 1) ? rlel_pkg::CTRL_NEW_LINE_B
                                                          : rlel_pkg::CTRL_NEW_LINE_A),
                         layer_start: 1'b0});
      end else if (pick < 35) begin
        body.push_back('{data_byte: 8'($urandom_range(1, 127)), layer_start: 1'b0});
      end else begin
        // Mostly short runs; now and then a long one, up to the full 127 pixels.
        if ($urandom_range(0, 99) < 5) begin
          cnt = $urandom_range(0, 1) ? 127 : $urandom_range(5, 126);
        end else begin
          cnt = $urandom_range(1, 4);
        end
        body.push_back('{data_byte: 8'(8'h80 | cnt), layer_start: 1'b0});
        repeat (2 * cnt) begin
          body.push_back('{data_byte: 8'($urandom_range(0, 255)), layer_start: 1'b0});
        end
      end
    end

    // Each control-stream byte costs exactly one unit of size.
    size = 32'(body.size());
    keep = 16 + body.size();
    mode = $urandom_range(0, 99);
    if (mode < 60) begin
      size = 32'(body.size());
    end else if (mode < 70) begin
      size = 32'($urandom_range(1, body.size()));
    end else if (mode < 78) begin
      size = ($urandom_range(0, 3) == 0) ? {1'b0, 31'($urandom)}
                                         : size + 32'($urandom_range(1, 40));
    end else if (mode < 86) begin
      size = $urandom_range(0, 1) ? 32'd0 : {1'b1, 31'($urandom)};
      keep = 16 + ((body.size() < 3) ? body.size() : 3);
    end

    whole.push_back('{data_byte: size[7:0], layer_start: 1'b1});
    whole.push_back('{data_byte: size[15:8], layer_start: 1'b0});
    whole.push_back('{data_byte: size[23:16], layer_start: 1'b0});
    whole.push_back('{data_byte: size[31:24], layer_start: 1'b0});
    repeat (12) begin
      whole.push_back('{data_byte: 8'($urandom_range(0, 255)), layer_start: 1'b0});
    end
    foreach (body[k]) begin
      whole.push_back(body[k]);
    end
    if (mode >= 86) begin
      keep = $urandom_range(1, whole.size() - 1);
    end
    for (int k = 0; k < keep; k++) begin
      stream_q.push_back(whole[k]);
    end
    random_bytes += keep;
    layer_count++;
  endtask

  initial begin
    int setting_no;
    rst <= 1'b1;
    in_valid <= 1'b0;
    in_data <= '0;
    cfg_we <= 1'b0;
    cfg_index <= rlel_pkg::REG_LAYER_BASE;
    cfg_data <= '0;
    quiet = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed layer at the reset configuration: size 9, both new-line
    // codes, the largest and smallest skips, then a two-pixel run of all
    // ones and all zeros whose last pixel ends the layer. Two more bytes
    // follow, which must be ignored because the layer is done.
    queue_byte(8'h09, 1'b1);
    for (int k = 1; k < 16; k++) begin
      queue_byte((k < 4) ? 8'h00 : 8'hFF, 1'b0);
    end
    queue_byte(rlel_pkg::CTRL_NEW_LINE_A, 1'b0);
    queue_byte(rlel_pkg::CTRL_NEW_LINE_B, 1'b0);
    queue_byte(8'h7F, 1'b0);
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h82, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'hFF, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h81, 1'b0);
    queue_byte(8'h00, 1'b0);
    send_stream();

    // Random part: each phase changes the configuration while the block is
    // idle, then streams a few layers. The settings rotate through the
    // base and pitch extremes, a zero pitch and the widest pitch value.
    setting_no = 0;
    while (random_bytes < RANDOM_BYTES) begin
      wait_idle();
      case (setting_no % 5)
        0: configure(24'h000000, 13'd4096);
        1: configure(24'hFFFFFF, 13'd1);
        2: configure(24'($urandom), 13'd0);
        3: configure(24'($urandom_range(24'hFFF000, 24'hFFFFFF)), 13'd8191);
        default: configure(24'($urandom), 13'($urandom_range(1, 4096)));
      endcase
      quiet = (setting_no % 4 == 2);
      for (int j = 0; j < 3 && random_bytes < RANDOM_BYTES; j++) begin
        add_layer();
        // Occasional stray bytes between layers; a few of them restart.
        if ($urandom_range(0, 9) == 0) begin
          repeat ($urandom_range(1, 4)) begin
            queue_byte(8'($urandom_range(0, 255)), $urandom_range(0, 19) == 0);
          end
        end
        send_stream();
      end
      setting_no++;
    end

    wait_idle();
    $display("Sent %0d stream bytes in %0d random layers over %0d register settings;",
             bytes_sent, layer_count, setting_count);
    $display("checked %0d pixel writes and %0d layer ends.", pixels_seen, ends_seen);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
